[rtl/core/dgbq_pkg.sv]
`default_nettype none

package dgbq_pkg;

    localparam int FRAC_BITS = 8;
    localparam int COL_BITS  = 8;
    localparam int ROW_BITS  = 8;
    localparam int GRID_COLS = 1 << COL_BITS;
    localparam int GRID_ROWS = 1 << ROW_BITS;
    localparam int ADDR_BITS = COL_BITS + ROW_BITS;
    localparam int CELLS     = 1 << ADDR_BITS;

    localparam int POS_W     = 24;
    localparam int POS_FRAC  = 16;
    localparam int DIST_W    = 16;
    localparam int GRAD_W    = 24;
    localparam int INV_W     = 16;
    localparam int DIM_W     = 9;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int STAT_W    = 2;
    localparam int CELL_W    = DIST_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_INV_RES     = 3'd2,
        CFG_GRID_WIDTH  = 3'd3,
        CFG_GRID_HEIGHT = 3'd4,
        CFG_FAR_DIST    = 3'd5
    } cfg_idx_t;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONFIN  = 2'd2;

    localparam logic signed [DIST_W-1:0] NONFINITE = 16'sh8000;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       mul;
        logic       chk;
        logic [1:0] rd_quad;
        logic       cap;
        logic [1:0] cap_quad;
        logic       mix;
        logic       prod;
        logic       fin;
    } dgbq_cmd_t;

    typedef struct packed {
        logic query;
        logic hit;
        logic clr_last;
    } dgbq_sts_t;

endpackage

`default_nettype wire

[rtl/core/dgbq_ram.sv]
`default_nettype none

module dgbq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/dgbq_ctrl.sv]
`default_nettype none

module dgbq_ctrl
    import dgbq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire dgbq_sts_t sts,
    output dgbq_cmd_t      cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CLEAR = 12'b0000_0000_0010,
        S_MUL   = 12'b0000_0000_0100,
        S_CHK   = 12'b0000_0000_1000,
        S_RD0   = 12'b0000_0001_0000,
        S_RD1   = 12'b0000_0010_0000,
        S_RD2   = 12'b0000_0100_0000,
        S_RD3   = 12'b0000_1000_0000,
        S_RD4   = 12'b0001_0000_0000,
        S_MIX   = 12'b0010_0000_0000,
        S_PROD  = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && sts.query)
                begin
                    state_next = S_MUL;
                end
            end
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:   state_next = S_CHK;
            S_CHK:   state_next = sts.hit ? S_RD0 : S_FIN;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_RD4;
            S_RD4:   state_next = S_MIX;
            S_MIX:   state_next = S_PROD;
            S_PROD:  state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.accept = (state_reg == S_IDLE) && start;
        cmd.clear  = (state_reg == S_CLEAR);
        cmd.mul    = (state_reg == S_MUL);
        cmd.chk    = (state_reg == S_CHK);
        cmd.mix    = (state_reg == S_MIX);
        cmd.prod   = (state_reg == S_PROD);
        cmd.fin    = (state_reg == S_FIN);
        unique case (state_reg)
            S_RD0:   cmd.rd_quad = 2'd0;
            S_RD1:   cmd.rd_quad = 2'd1;
            S_RD2:   cmd.rd_quad = 2'd2;
            S_RD3:   cmd.rd_quad = 2'd3;
            default: cmd.rd_quad = 2'd0;
        endcase
        unique case (state_reg)
            S_RD1:
            begin
                cmd.cap      = 1'b1;
                cmd.cap_quad = 2'd0;
            end
            S_RD2:
            begin
                cmd.cap      = 1'b1;
                cmd.cap_quad = 2'd1;
            end
            S_RD3:
            begin
                cmd.cap      = 1'b1;
                cmd.cap_quad = 2'd2;
            end
            S_RD4:
            begin
                cmd.cap      = 1'b1;
                cmd.cap_quad = 2'd3;
            end
            default:
            begin
                cmd.cap      = 1'b0;
                cmd.cap_quad = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/core/dgbq_dpath.sv]
`default_nettype none

module dgbq_dpath
    import dgbq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     mode,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic [COL_BITS-1:0]      cell_x,
    input  wire logic [ROW_BITS-1:0]      cell_y,
    input  wire logic signed [DIST_W-1:0] cell_value,
    input  wire dgbq_cmd_t                cmd,
    output dgbq_sts_t                     sts,
    output logic signed [DIST_W-1:0]      distance,
    output logic signed [GRAD_W-1:0]      grad_x,
    output logic signed [GRAD_W-1:0]      grad_y,
    output logic [STAT_W-1:0]             status
);

    localparam int W_W     = FRAC_BITS + 2;
    localparam int L_W     = W_W + DIST_W + 1;
    localparam int E_W     = DIST_W + 1;
    localparam int D_W     = W_W + E_W + 1;
    localparam int A_W     = W_W + L_W + 1;
    localparam int INV_S_W = INV_W + 1;
    localparam int G_W     = D_W + INV_S_W;
    localparam int DX_W    = POS_W + 1;
    localparam int PX_W    = DX_W + INV_S_W;
    localparam int IXF_W   = PX_W - 1 - POS_FRAC;
    localparam int DSH     = 2 * FRAC_BITS;
    localparam int GSH     = 8 + FRAC_BITS;

    localparam logic signed [A_W-1:0]    D_HALF   = A_W'(longint'(1) << (DSH - 1));
    localparam logic signed [G_W-1:0]    G_HALF   = G_W'(longint'(1) << (GSH - 1));
    localparam logic signed [G_W-1:0]    G_MAX    = G_W'(longint'(8388607));
    localparam logic signed [G_W-1:0]    G_MIN    = G_W'(-longint'(8388608));
    localparam logic signed [W_W-1:0]    W_ONE    = W_W'(1 << FRAC_BITS);
    localparam logic [DIM_W-1:0]         COLS_LIM = DIM_W'(GRID_COLS);
    localparam logic [DIM_W-1:0]         ROWS_LIM = DIM_W'(GRID_ROWS);

    function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [G_W-1:0] v);
        logic signed [GRAD_W-1:0] r;
        if (v > G_MAX)
        begin
            r = G_MAX[GRAD_W-1:0];
        end
        else if (v < G_MIN)
        begin
            r = G_MIN[GRAD_W-1:0];
        end
        else
        begin
            r = v[GRAD_W-1:0];
        end
        return r;
    endfunction

    logic signed [POS_W-1:0]  origin_x_reg;
    logic signed [POS_W-1:0]  origin_y_reg;
    logic [INV_W-1:0]         inv_res_reg;
    logic [DIM_W-1:0]         grid_width_reg;
    logic [DIM_W-1:0]         grid_height_reg;
    logic signed [DIST_W-1:0] far_dist_reg;
    logic [ADDR_BITS-1:0]     clr_addr_reg;

    logic [DIM_W-1:0]         w_used;
    logic [DIM_W-1:0]         h_used;
    logic                     grid_ok;
    logic                     wr_hit;

    logic                     ram_we;
    logic [ADDR_BITS-1:0]     ram_waddr;
    logic [CELL_W-1:0]        ram_wdata;
    logic [ADDR_BITS-1:0]     ram_raddr;
    logic [CELL_W-1:0]        ram_rdata;

    logic signed [DX_W-1:0]   dx_reg;
    logic signed [DX_W-1:0]   dy_reg;
    logic signed [PX_W-1:0]   px_reg;
    logic signed [PX_W-1:0]   py_reg;
    logic signed [PX_W-1:0]   px_next;
    logic signed [PX_W-1:0]   py_next;
    logic signed [INV_S_W-1:0] inv_s;

    logic [IXF_W-1:0]         ix_full;
    logic [IXF_W-1:0]         iy_full;
    logic                     q_hit;
    logic [COL_BITS-1:0]      ix_reg;
    logic [ROW_BITS-1:0]      iy_reg;
    logic [FRAC_BITS-1:0]     fx_reg;
    logic [FRAC_BITS-1:0]     fy_reg;

    logic signed [DIST_W-1:0] d_reg [4];
    logic signed [DIST_W-1:0] cell_rd;
    logic                     any_nonfin;

    logic signed [W_W-1:0]    wx0;
    logic signed [W_W-1:0]    wx1;
    logic signed [W_W-1:0]    wy0;
    logic signed [W_W-1:0]    wy1;
    logic signed [E_W-1:0]    e10_00;
    logic signed [E_W-1:0]    e11_01;
    logic signed [E_W-1:0]    e01_00;
    logic signed [E_W-1:0]    e11_10;
    logic signed [L_W-1:0]    l0_reg;
    logic signed [L_W-1:0]    l1_reg;
    logic signed [D_W-1:0]    ddx_reg;
    logic signed [D_W-1:0]    ddy_reg;
    logic signed [A_W-1:0]    acc_reg;
    logic signed [G_W-1:0]    gxp_reg;
    logic signed [G_W-1:0]    gyp_reg;
    logic signed [A_W-1:0]    dist_sh;
    logic signed [G_W-1:0]    gx_sh;
    logic signed [G_W-1:0]    gy_sh;

    logic [STAT_W-1:0]        stat_reg;
    logic signed [DIST_W-1:0] distance_reg;
    logic signed [GRAD_W-1:0] grad_x_reg;
    logic signed [GRAD_W-1:0] grad_y_reg;
    logic [STAT_W-1:0]        status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            inv_res_reg     <= INV_W'(2560);
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
            far_dist_reg    <= 16'sd32767;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X:    origin_x_reg    <= signed'(cfg_data[POS_W-1:0]);
                CFG_ORIGIN_Y:    origin_y_reg    <= signed'(cfg_data[POS_W-1:0]);
                CFG_INV_RES:     inv_res_reg     <= cfg_data[INV_W-1:0];
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                CFG_FAR_DIST:    far_dist_reg    <= signed'(cfg_data[DIST_W-1:0]);
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
        end
    end

    assign w_used  = (grid_width_reg > COLS_LIM) ? COLS_LIM : grid_width_reg;
    assign h_used  = (grid_height_reg > ROWS_LIM) ? ROWS_LIM : grid_height_reg;
    assign grid_ok = (inv_res_reg != '0) && (w_used > DIM_W'(1)) && (h_used > DIM_W'(1));
    assign wr_hit  = (DIM_W'(cell_x) < w_used) && (DIM_W'(cell_y) < h_used);

    always_comb
    begin
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.accept && !mode && wr_hit;
            ram_waddr = {cell_y, cell_x};
            ram_wdata = {1'b1, cell_value};
        end
    end

    assign ram_raddr = {iy_reg + ROW_BITS'(cmd.rd_quad[1]), ix_reg + COL_BITS'(cmd.rd_quad[0])};

    dgbq_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign inv_s   = signed'({1'b0, inv_res_reg});
    assign px_next = PX_W'(dx_reg) * PX_W'(inv_s);
    assign py_next = PX_W'(dy_reg) * PX_W'(inv_s);

    assign ix_full = px_reg[PX_W-2:POS_FRAC];
    assign iy_full = py_reg[PX_W-2:POS_FRAC];
    assign q_hit   = grid_ok && !px_reg[PX_W-1] && !py_reg[PX_W-1]
                     && (ix_full < IXF_W'(w_used - DIM_W'(1)))
                     && (iy_full < IXF_W'(h_used - DIM_W'(1)));

    assign cell_rd = ram_rdata[CELL_W-1] ? signed'(ram_rdata[DIST_W-1:0]) : far_dist_reg;

    assign any_nonfin = (d_reg[0] == NONFINITE) || (d_reg[1] == NONFINITE)
                        || (d_reg[2] == NONFINITE) || (d_reg[3] == NONFINITE);

    assign wx1 = signed'({2'b00, fx_reg});
    assign wx0 = W_ONE - wx1;
    assign wy1 = signed'({2'b00, fy_reg});
    assign wy0 = W_ONE - wy1;

    assign e10_00 = E_W'(d_reg[1]) - E_W'(d_reg[0]);
    assign e11_01 = E_W'(d_reg[3]) - E_W'(d_reg[2]);
    assign e01_00 = E_W'(d_reg[2]) - E_W'(d_reg[0]);
    assign e11_10 = E_W'(d_reg[3]) - E_W'(d_reg[1]);

    assign dist_sh = (acc_reg + D_HALF) >>> DSH;
    assign gx_sh   = (gxp_reg + G_HALF) >>> GSH;
    assign gy_sh   = (gyp_reg + G_HALF) >>> GSH;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dx_reg <= DX_W'(pos_x) - DX_W'(origin_x_reg);
            dy_reg <= DX_W'(pos_y) - DX_W'(origin_y_reg);
        end
        if (cmd.mul)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (cmd.chk)
        begin
            ix_reg   <= px_reg[POS_FRAC +: COL_BITS];
            iy_reg   <= py_reg[POS_FRAC +: ROW_BITS];
            fx_reg   <= px_reg[POS_FRAC-1 -: FRAC_BITS];
            fy_reg   <= py_reg[POS_FRAC-1 -: FRAC_BITS];
            stat_reg <= q_hit ? ST_OK : ST_OUTSIDE;
        end
        if (cmd.cap)
        begin
            d_reg[cmd.cap_quad] <= cell_rd;
        end
        if (cmd.mix)
        begin
            l0_reg  <= L_W'(wx0) * L_W'(d_reg[0]) + L_W'(wx1) * L_W'(d_reg[1]);
            l1_reg  <= L_W'(wx0) * L_W'(d_reg[2]) + L_W'(wx1) * L_W'(d_reg[3]);
            ddx_reg <= D_W'(wy0) * D_W'(e10_00) + D_W'(wy1) * D_W'(e11_01);
            ddy_reg <= D_W'(wx0) * D_W'(e01_00) + D_W'(wx1) * D_W'(e11_10);
            if (any_nonfin)
            begin
                stat_reg <= ST_NONFIN;
            end
        end
        if (cmd.prod)
        begin
            acc_reg <= A_W'(wy0) * A_W'(l0_reg) + A_W'(wy1) * A_W'(l1_reg);
            gxp_reg <= G_W'(ddx_reg) * G_W'(inv_s);
            gyp_reg <= G_W'(ddy_reg) * G_W'(inv_s);
        end
        if (cmd.fin)
        begin
            status_reg <= stat_reg;
            unique case (stat_reg)
                ST_OK:
                begin
                    distance_reg <= dist_sh[DIST_W-1:0];
                    grad_x_reg   <= sat_grad(gx_sh);
                    grad_y_reg   <= sat_grad(gy_sh);
                end
                ST_NONFIN:
                begin
                    distance_reg <= NONFINITE;
                    grad_x_reg   <= '0;
                    grad_y_reg   <= '0;
                end
                default:
                begin
                    distance_reg <= far_dist_reg;
                    grad_x_reg   <= '0;
                    grad_y_reg   <= '0;
                end
            endcase
        end
    end

    assign sts.query    = mode;
    assign sts.hit      = q_hit;
    assign sts.clr_last = &clr_addr_reg;

    assign distance = distance_reg;
    assign grad_x   = grad_x_reg;
    assign grad_y   = grad_y_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

[rtl/core/distance_grid_bilinear_query_unit.sv]
// Channel   Beat on                  Ports
// --------  -----------------------  --------------------------------------------------
// item in   start && !busy           mode, pos_x, pos_y, cell_x, cell_y, cell_value
// result    done (one cycle)         distance, grad_x, grad_y, status
// config    cfg_we                   cfg_index, cfg_data
//
// A cell write gives no result; the next beat may follow at once.
// A query raises done after a multiply step, a range check, four reads of the
// single-read-port grid memory plus its read latency, two arithmetic stages and an
// output load. A query outside the grid skips the reads and the arithmetic stages.
// After reset busy holds high while the written marks of all 65536 cells are cleared.
// Results cannot be stalled; each holds on the ports until the next query replaces it.
`default_nettype none

module distance_grid_bilinear_query_unit
    import dgbq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    output logic                          done,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     mode,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic [COL_BITS-1:0]      cell_x,
    input  wire logic [ROW_BITS-1:0]      cell_y,
    input  wire logic signed [DIST_W-1:0] cell_value,
    output logic signed [DIST_W-1:0]      distance,
    output logic signed [GRAD_W-1:0]      grad_x,
    output logic signed [GRAD_W-1:0]      grad_y,
    output logic [STAT_W-1:0]             status
);

    dgbq_cmd_t cmd;
    dgbq_sts_t sts;

    dgbq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dgbq_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_value (cell_value),
        .cmd        (cmd),
        .sts        (sts),
        .distance   (distance),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .status     (status)
    );

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !mode) |=> !done)
        else $error("cell write produced a result");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode) |=> busy)
        else $error("query beat did not start work");

    a_fail_grad: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_OUTSIDE || status == ST_NONFIN)) |->
        (grad_x == '0 && grad_y == '0))
        else $error("failed query with nonzero gradient");

    a_nonfin_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NONFIN) |-> (distance == NONFINITE))
        else $error("non-finite query without marker distance");
`endif

endmodule

`default_nettype wire

[bench/distance_grid_bilinear_query_unit_test.sv]
module distance_grid_bilinear_query_unit_test
    import dgbq_pkg::*;
;

    localparam int     HOLD_OFF     = 16;
    localparam int     QUIET_TAIL   = 100;
    localparam int     DRAIN_CYCLES = 24;
    localparam longint LIMIT_CYCLES = 400000;
    localparam longint GRAD_MAX     = 8388607;
    localparam longint GRAD_MIN     = -8388608;

    typedef struct packed {
        logic                 is_cfg;
        cfg_idx_t             idx;
        logic [CFG_W-1:0]     data;
        logic                 mode;
        logic [POS_W-1:0]     px;
        logic [POS_W-1:0]     py;
        logic [COL_BITS-1:0]  cx;
        logic [ROW_BITS-1:0]  cy;
        logic [DIST_W-1:0]    val;
    } plan_entry_t;

    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic [STAT_W-1:0] stat;
    } lookup_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    logic                     busy;
    logic                     done;
    logic                     cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [CFG_W-1:0]         cfg_data   = '0;
    logic                     mode       = 1'b0;
    logic signed [POS_W-1:0]  pos_x      = '0;
    logic signed [POS_W-1:0]  pos_y      = '0;
    logic [COL_BITS-1:0]      cell_x     = '0;
    logic [ROW_BITS-1:0]      cell_y     = '0;
    logic signed [DIST_W-1:0] cell_value = '0;
    logic signed [DIST_W-1:0] distance;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [STAT_W-1:0]        status;

    distance_grid_bilinear_query_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_value (cell_value),
        .distance   (distance),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .status     (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the block: registers and grid
    logic signed [POS_W-1:0]  org_x    = '0;
    logic signed [POS_W-1:0]  org_y    = '0;
    logic [INV_W-1:0]         inv_res  = 16'd2560;
    logic [DIM_W-1:0]         grid_w   = '0;
    logic [DIM_W-1:0]         grid_h   = '0;
    logic signed [DIST_W-1:0] far_dist = 16'sd32767;
    logic signed [DIST_W-1:0] grid_val [CELLS];
    bit                       grid_mark [CELLS];

    lookup_t     lookups_due[$];
    plan_entry_t beats_planned[$];
    logic        item_beat     = 1'b0;
    int          entries_done  = 0;
    int          fail_count    = 0;
    int          gap_left      = 0;
    int          settle        = 0;
    int          idle_pct      = 25;
    longint      cycle_count   = 0;

    // stimulus-side copy of the configuration
    longint p_ox  = 0;
    longint p_oy  = 0;
    longint p_inv = 2560;
    longint p_w   = 0;
    longint p_h   = 0;

    function automatic int usable_cols();
        return (grid_w < GRID_COLS) ? int'(grid_w) : GRID_COLS;
    endfunction

    function automatic int usable_rows();
        return (grid_h < GRID_ROWS) ? int'(grid_h) : GRID_ROWS;
    endfunction

    function automatic longint cell_read(input longint col, input longint row);
        int a;
        a = int'(row) * GRID_COLS + int'(col);
        return grid_mark[a] ? longint'(grid_val[a]) : longint'(far_dist);
    endfunction

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat_grad(input longint v);
        if (v > GRAD_MAX)
            return GRAD_MAX;
        if (v < GRAD_MIN)
            return GRAD_MIN;
        return v;
    endfunction

    function automatic lookup_t interp_lookup(input logic signed [POS_W-1:0] qpx,
                                              input logic signed [POS_W-1:0] qpy);
        lookup_t r;
        longint  one, uw, uh, px, py, ix, iy, fx, fy;
        longint  d00, d10, d01, d11, l0, l1, ddx, ddy;
        one    = longint'(1) << FRAC_BITS;
        uw     = usable_cols();
        uh     = usable_rows();
        r.dval = far_dist;
        r.gx   = '0;
        r.gy   = '0;
        r.stat = ST_OUTSIDE;
        if (inv_res != 0 && uw > 1 && uh > 1)
        begin
            px = (longint'(qpx) - longint'(org_x)) * longint'(inv_res);
            py = (longint'(qpy) - longint'(org_y)) * longint'(inv_res);
            if (px >= 0 && py >= 0)
            begin
                ix = px >>> POS_FRAC;
                iy = py >>> POS_FRAC;
                fx = (px >>> (POS_FRAC - FRAC_BITS)) & (one - 1);
                fy = (py >>> (POS_FRAC - FRAC_BITS)) & (one - 1);
                if (ix < uw - 1 && iy < uh - 1)
                begin
                    d00 = cell_read(ix, iy);
                    d10 = cell_read(ix + 1, iy);
                    d01 = cell_read(ix, iy + 1);
                    d11 = cell_read(ix + 1, iy + 1);
                    if (d00 == NONFINITE || d10 == NONFINITE ||
                        d01 == NONFINITE || d11 == NONFINITE)
                    begin
                        r.dval = NONFINITE;
                        r.stat = ST_NONFIN;
                    end
                    else
                    begin
                        l0     = (one - fx) * d00 + fx * d10;
                        l1     = (one - fx) * d01 + fx * d11;
                        ddx    = (one - fy) * (d10 - d00) + fy * (d11 - d01);
                        ddy    = (one - fx) * (d01 - d00) + fx * (d11 - d10);
                        r.dval = DIST_W'(round_half_up((one - fy) * l0 + fy * l1,
                                                       2 * FRAC_BITS));
                        r.gx   = GRAD_W'(sat_grad(round_half_up(ddx * longint'(inv_res),
                                                                8 + FRAC_BITS)));
                        r.gy   = GRAD_W'(sat_grad(round_half_up(ddy * longint'(inv_res),
                                                                8 + FRAC_BITS)));
                        r.stat = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    // stimulus planning
    task automatic put_reg(input cfg_idx_t idx, input longint v);
        plan_entry_t e;
        e        = '0;
        e.is_cfg = 1'b1;
        e.idx    = idx;
        e.data   = CFG_W'(v);
        case (idx)
            CFG_ORIGIN_X:    p_ox  = v;
            CFG_ORIGIN_Y:    p_oy  = v;
            CFG_INV_RES:     p_inv = v;
            CFG_GRID_WIDTH:  p_w   = v;
            CFG_GRID_HEIGHT: p_h   = v;
            default:         ;
        endcase
        beats_planned.push_back(e);
    endtask

    task automatic put_item(input logic m, input longint px, input longint py,
                            input longint cx, input longint cy, input longint val);
        plan_entry_t e;
        e      = '0;
        e.mode = m;
        e.px   = POS_W'(px);
        e.py   = POS_W'(py);
        e.cx   = COL_BITS'(cx);
        e.cy   = ROW_BITS'(cy);
        e.val  = DIST_W'(val);
        beats_planned.push_back(e);
    endtask

    task automatic put_write(input longint cx, input longint cy, input longint val);
        put_item(1'b0, $urandom(), $urandom(), cx, cy, val);
    endtask

    task automatic put_query(input longint px, input longint py);
        put_item(1'b1, px, py, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
    endtask

    function automatic longint clip_pos(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint pick_origin();
        case ($urandom_range(0, 9))
            0:       return -8388608;
            1:       return 8388607;
            default: return longint'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic longint pick_dim();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 1;
            2:       return 256;
            3:       return $urandom_range(2, 256);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    function automatic longint pick_dist();
        case ($urandom_range(0, 19))
            0:       return -32768;
            1:       return 32767;
            2:       return -32767;
            3, 4, 5: return longint'($urandom_range(0, 1023)) - 512;
            default: return longint'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic put_aimed_query();
        longint qx, qy;
        if (p_inv == 0 || p_w < 2 || p_h < 2 || $urandom_range(0, 9) == 0)
            put_query($urandom(), $urandom());
        else
        begin
            qx = longint'($urandom_range(0, int'(p_w - 1) * 256 + 48)) - 24;
            qy = longint'($urandom_range(0, int'(p_h - 1) * 256 + 48)) - 24;
            put_query(clip_pos(p_ox + (qx * 256) / p_inv + $urandom_range(0, 1)),
                      clip_pos(p_oy + (qy * 256) / p_inv + $urandom_range(0, 1)));
        end
    endtask

    task automatic random_phase(input int n);
        int k;
        if ($urandom_range(0, 9) < 7)
            put_reg(CFG_ORIGIN_X, pick_origin());
        if ($urandom_range(0, 9) < 7)
            put_reg(CFG_ORIGIN_Y, pick_origin());
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 11))
                0:       put_reg(CFG_INV_RES, 0);
                1:       put_reg(CFG_INV_RES, 65535);
                2:       put_reg(CFG_INV_RES, 1);
                3:       put_reg(CFG_INV_RES, 256);
                default: put_reg(CFG_INV_RES, $urandom_range(16, 4096));
            endcase
        end
        if ($urandom_range(0, 9) < 7)
            put_reg(CFG_GRID_WIDTH, pick_dim());
        if ($urandom_range(0, 9) < 7)
            put_reg(CFG_GRID_HEIGHT, pick_dim());
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 7))
                0:       put_reg(CFG_FAR_DIST, -32767);
                1:       put_reg(CFG_FAR_DIST, 32767);
                default: put_reg(CFG_FAR_DIST, longint'($urandom_range(0, 65534)) - 32767);
            endcase
        end
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                if (p_w > 0 && p_h > 0 && $urandom_range(0, 9) != 0)
                    put_write($urandom_range(0, int'(p_w - 1)),
                              $urandom_range(0, int'(p_h - 1)), pick_dist());
                else
                    put_write($urandom_range(0, 255), $urandom_range(0, 255), pick_dist());
            end
            else
                put_aimed_query();
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        plan_entry_t e;
        logic        nx_start;
        logic        nx_we;
        nx_start = start;
        nx_we    = 1'b0;
        if (rst_n && !(start && !item_beat))
        begin
            nx_start = 1'b0;
            if (item_beat && beats_planned.size() > QUIET_TAIL)
            begin
                if ($urandom_range(0, 31) == 0)
                    idle_pct = $urandom_range(0, 2) * 25;
                if ($urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(1, 11);
            end
            if (gap_left > 0)
                gap_left--;
            else if (beats_planned.size() != 0)
            begin
                if (beats_planned[0].is_cfg)
                begin
                    // hold register writes until the block has drained
                    if (lookups_due.size() != 0 || busy)
                        settle = 0;
                    else if (settle < HOLD_OFF)
                        settle++;
                    else
                    begin
                        e = beats_planned.pop_front();
                        nx_we     = 1'b1;
                        cfg_index <= e.idx;
                        cfg_data  <= e.data;
                    end
                end
                else
                begin
                    e = beats_planned.pop_front();
                    nx_start   = 1'b1;
                    settle     = 0;
                    mode       <= e.mode;
                    pos_x      <= e.px;
                    pos_y      <= e.py;
                    cell_x     <= e.cx;
                    cell_y     <= e.cy;
                    cell_value <= e.val;
                end
            end
        end
        start  <= nx_start;
        cfg_we <= nx_we;
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        lookup_t want;
        item_beat <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (lookups_due.size() == 0)
                begin
                    $error("result beat with no query outstanding");
                    fail_count++;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (distance !== want.dval)
                    begin
                        $error("distance: expected %0d, got %0d",
                               $signed(want.dval), distance);
                        fail_count++;
                    end
                    if (grad_x !== want.gx)
                    begin
                        $error("grad_x: expected %0d, got %0d", $signed(want.gx), grad_x);
                        fail_count++;
                    end
                    if (grad_y !== want.gy)
                    begin
                        $error("grad_y: expected %0d, got %0d", $signed(want.gy), grad_y);
                        fail_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, got %0d", want.stat, status);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                entries_done++;
                case (cfg_idx_t'(cfg_index))
                    CFG_ORIGIN_X:    org_x    = cfg_data;
                    CFG_ORIGIN_Y:    org_y    = cfg_data;
                    CFG_INV_RES:     inv_res  = cfg_data[INV_W-1:0];
                    CFG_GRID_WIDTH:  grid_w   = cfg_data[DIM_W-1:0];
                    CFG_GRID_HEIGHT: grid_h   = cfg_data[DIM_W-1:0];
                    CFG_FAR_DIST:    far_dist = cfg_data[DIST_W-1:0];
                    default:         ;
                endcase
            end
            if (start && !busy)
            begin
                entries_done++;
                if (mode)
                    lookups_due.push_back(interp_lookup(pos_x, pos_y));
                else if (int'(cell_x) < usable_cols() && int'(cell_y) < usable_rows())
                begin
                    grid_val[int'(cell_y) * GRID_COLS + int'(cell_x)]  = cell_value;
                    grid_mark[int'(cell_y) * GRID_COLS + int'(cell_x)] = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int total;
        int ph;
        // reset configuration: empty grid
        put_query(0, 0);
        put_write(0, 0, 100);
        put_reg(CFG_ORIGIN_X, 0);
        put_reg(CFG_ORIGIN_Y, 0);
        put_reg(CFG_INV_RES, 256);
        put_reg(CFG_GRID_WIDTH, 4);
        put_reg(CFG_GRID_HEIGHT, 3);
        put_reg(CFG_FAR_DIST, 1000);
        put_write(0, 0, 32767);
        put_write(1, 0, -32767);
        put_write(0, 1, 0);
        put_write(1, 1, 256);
        put_write(4, 0, 5);
        put_write(0, 3, 5);
        put_write(2, 1, -32768);
        put_query(0, 0);
        put_query(128, 64);
        put_query(255, 255);
        put_query(100, 333);
        put_query(384, 300);
        put_query(-1, 0);
        put_query(768, 0);
        put_query(0, 512);
        put_query(8388607, -8388608);
        put_write(0, 2, -32767);
        put_write(1, 2, 32767);
        // steep cells at the finest resolution drive the gradients into saturation
        put_reg(CFG_INV_RES, 65535);
        put_reg(CFG_FAR_DIST, -32767);
        put_query(0, 0);
        put_query(0, 2);
        put_reg(CFG_INV_RES, 0);
        put_query(0, 0);
        put_reg(CFG_INV_RES, 256);
        put_reg(CFG_GRID_HEIGHT, 1);
        put_query(0, 0);
        put_reg(CFG_GRID_HEIGHT, 3);
        put_reg(CFG_ORIGIN_X, -8388608);
        put_reg(CFG_ORIGIN_Y, 8388607);
        put_query(8388607, 8388607);
        put_query(-8388608, 8388607);
        for (ph = 0; ph < 11; ph++)
            random_phase(105);
        total = beats_planned.size();

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (entries_done != total || lookups_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
